// ----- design/assert_macros.svh -----
// assertion macros used by the port-level checker in atlr_checker.sv
// no dependencies; clock aclk and reset aresetn must be visible where used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ATLR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ATLR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- design/atlr_pkg.sv -----
// shared types and constants of the thick line rasterizer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package atlr_pkg;

    localparam int COORD_BITS_DEF  = 12;
    localparam int MAX_SPAN_DEF    = 64;
    localparam int PIX_W           = 32;
    localparam int WIDTH_W         = 8;
    localparam int SHIFT_W         = 5;
    localparam int RECIP_W         = 24;
    localparam int RECIP_HALF      = 12;
    localparam int NUM_W           = 32;
    localparam int SQ_FRAC         = 16;
    localparam int LIM_SHIFT       = 12;
    localparam int WQ_SHIFT        = 19;
    localparam int ALPHA_FRAC      = 23;
    localparam int WIDTH_ONE       = 16;
    localparam int LEN_ONE         = 256;
    localparam int CNT_W           = 6;

    localparam logic [SHIFT_W-1:0] ALPHA_SHIFT_RST = 5'd24;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    // register index taken from paddr[2]
    localparam logic REG_ALPHA_SHIFT = 1'b0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQX,
        ST_SQY,
        ST_ROOT,
        ST_RFIX,
        ST_DIV,
        ST_LIM,
        ST_M1,
        ST_M2,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        PH_CENTRE,
        PH_XSPAN,
        PH_YSPAN
    } phase_t;

endpackage

`default_nettype wire

// ----- design/antialiased_thick_line_raster.sv -----
// Anti-aliased thick line rasterizer. A load beat (command 0) takes both endpoints,
// the Q4.4 weight and the base colour word; the block then runs a bit-per-cycle
// square root for the Q13.8 length and a bit-per-cycle reciprocal, with the
// setup states SQX, SQY, RFIX and LIM around them, and is not ready meanwhile; a
// single point skips the root.
// A step beat (command 1) walks one Bresenham iteration and emits the centre pixel
// followed by the perpendicular span pixels, at most MAX_SPAN_PIXELS pixels in all;
// each pixel takes two partial products of |e|/length through the one shared
// (COORD_BITS+9)x(max of COORD_BITS and 12) multiplier, then alpha and the output
// beat; the block stays busy for the whole step, output stalls included.
// last_of_step marks the final pixel of a step, line_done marks every pixel
// of the step that reaches the endpoint. A step while no line is active is taken
// and produces nothing. alpha_shift sits at byte address 0 of the APB port.
// depends on atlr_pkg and atlr_alpha
`timescale 1ns / 1ps
`default_nettype none

module antialiased_thick_line_raster #(
    parameter int COORD_BITS      = atlr_pkg::COORD_BITS_DEF,
    parameter int MAX_SPAN_PIXELS = atlr_pkg::MAX_SPAN_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // command beats
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_command,
    input  wire logic [COORD_BITS-1:0]         s_x_start,
    input  wire logic [COORD_BITS-1:0]         s_y_start,
    input  wire logic [COORD_BITS-1:0]         s_x_end,
    input  wire logic [COORD_BITS-1:0]         s_y_end,
    input  wire logic [atlr_pkg::WIDTH_W-1:0]  s_line_width,
    input  wire logic [atlr_pkg::PIX_W-1:0]    s_base_pixel,
    // pixel beats
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [COORD_BITS-1:0]         m_pixel_x,
    output logic      [COORD_BITS-1:0]         m_pixel_y,
    output logic      [atlr_pkg::PIX_W-1:0]    m_pixel_value,
    output logic                               m_last_of_step,
    output logic                               m_line_done,
    // register port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [2:0]                    paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready
);

    // widths that follow from the coordinate size
    localparam int C      = COORD_BITS;
    localparam int ERR_W  = C + 3;                 // walk error
    localparam int E_W    = C + 9;                 // local pixel error
    localparam int SQ_W   = 2 * C + 1;             // dx^2 + dy^2
    localparam int V_W    = SQ_W + atlr_pkg::SQ_FRAC;
    localparam int ROOT_W = C + 9;                 // Q.8 length
    localparam int MA_W   = (E_W > ROOT_W) ? E_W : ROOT_W;
    localparam int MB_W   = (C > atlr_pkg::RECIP_HALF) ? C : atlr_pkg::RECIP_HALF;
    localparam int PROD_W = MA_W + MB_W;
    localparam int QW     = MA_W + atlr_pkg::RECIP_W;
    localparam int LIM_W  = ROOT_W + 9;
    localparam int CMP_W  = ((E_W + atlr_pkg::LIM_SHIFT > LIM_W) ?
                             E_W + atlr_pkg::LIM_SHIFT : LIM_W) + 1;
    localparam int N_W    = $clog2(MAX_SPAN_PIXELS + 1);

    // control state
    atlr_pkg::state_t state_reg, state_next;
    atlr_pkg::phase_t phase_reg, phase_next;
    logic                          active_reg, active_next;
    logic [atlr_pkg::SHIFT_W-1:0]  shift_reg, shift_next;
    logic                          m_valid_reg, m_valid_next;

    // line state
    logic [C-1:0]                  cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    logic [C-1:0]                  end_x_reg, end_x_next, end_y_reg, end_y_next;
    logic [C-1:0]                  adx_reg, adx_next, ady_reg, ady_next;
    logic                          sxn_reg, sxn_next, syn_reg, syn_next;
    logic signed [ERR_W-1:0]       err_reg, err_next;
    logic [ROOT_W-1:0]             len_reg, len_next;
    logic [atlr_pkg::RECIP_W-1:0]  recip_reg, recip_next;
    logic [atlr_pkg::WIDTH_W-1:0]  width_reg, width_next;
    logic [atlr_pkg::PIX_W-1:0]    base_reg, base_next;
    logic [LIM_W-1:0]              lim_reg, lim_next;

    // shared iterative unit
    logic [SQ_W-1:0]               acc_reg, acc_next;
    logic [V_W-1:0]                rem_reg, rem_next;
    logic [V_W-1:0]                root_reg, root_next;
    logic [V_W-1:0]                bit_reg, bit_next;
    logic [atlr_pkg::NUM_W-1:0]    num_reg, num_next;
    logic [atlr_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic [PROD_W-1:0]             prod_reg, prod_next;
    logic [QW-1:0]                 q_reg, q_next;

    // current pixel and step flags
    logic [C-1:0]                  pix_x_reg, pix_x_next, pix_y_reg, pix_y_next;
    logic signed [E_W-1:0]         epix_reg, epix_next;
    logic [N_W-1:0]                n_reg, n_next;
    logic                          xph_reg, xph_next, yph_reg, yph_next;
    logic                          donex_reg, donex_next, done_reg, done_next;

    // output register
    logic [C-1:0]                  mx_reg, mx_next, my_reg, my_next;
    logic [atlr_pkg::PIX_W-1:0]    mval_reg, mval_next;
    logic                          mlast_reg, mlast_next, mdone_reg, mdone_next;

    // shared multiplier
    logic [MA_W-1:0]               mul_a;
    logic [MB_W-1:0]               mul_b;
    logic [PROD_W-1:0]             mul_p;

    logic [E_W-1:0]                mag;
    logic [atlr_pkg::PIX_W-1:0]    pix_value;

    // combinational helpers
    logic                          s_fire, out_free;
    logic [C-1:0]                  sx_add, sy_add;
    logic signed [E_W-1:0]         keep2, e0, ex0, ey0, exn, eyn;
    logic                          xph_c, yph_raw_c, donex_c;
    logic                          budget, y_start;
    logic                          has_next;
    atlr_pkg::phase_t              nph;
    logic [C-1:0]                  nx, ny;
    logic signed [E_W-1:0]         ne;
    logic [SQ_W-1:0]               sq;
    logic [V_W-1:0]                trial, rootv;
    logic [ROOT_W:0]               dt;
    logic [ROOT_W-1:0]             lenv;
    logic signed [ERR_W-1:0]       err1;

    // span test: e * 4096 < length * (weight + 1)
    function automatic logic lt_lim(input logic signed [E_W-1:0] e,
                                    input logic [LIM_W-1:0] lim);
        logic signed [CMP_W-1:0] a;
        logic signed [CMP_W-1:0] b;
        a = CMP_W'(e) <<< atlr_pkg::LIM_SHIFT;
        b = $signed(CMP_W'(lim));
        return a < b;
    endfunction

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign mag   = epix_reg[E_W-1] ? E_W'(-epix_reg) : E_W'(epix_reg);

    atlr_alpha #(
        .QW (QW)
    ) u_alpha (
        .q          (q_reg),
        .line_width (width_reg),
        .base       (base_reg),
        .shift      (shift_reg),
        .value      (pix_value)
    );

    assign s_ready  = (state_reg == atlr_pkg::ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign m_valid        = m_valid_reg;
    assign m_pixel_x      = mx_reg;
    assign m_pixel_y      = my_reg;
    assign m_pixel_value  = mval_reg;
    assign m_last_of_step = mlast_reg;
    assign m_line_done    = mdone_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == atlr_pkg::REG_ALPHA_SHIFT) ? 32'(shift_reg) : 32'd0;

    // walk directions and per-step decisions
    always_comb begin
        sx_add    = sxn_reg ? {C{1'b1}} : C'(1);
        sy_add    = syn_reg ? {C{1'b1}} : C'(1);
        keep2     = E_W'(err_reg) <<< 1;
        e0        = E_W'(err_reg) - $signed(E_W'(adx_reg)) + $signed(E_W'(ady_reg));
        ex0       = E_W'(err_reg) + $signed(E_W'(ady_reg));
        ey0       = $signed(E_W'(adx_reg)) - E_W'(err_reg);
        exn       = epix_reg + $signed(E_W'(adx_reg));
        eyn       = epix_reg + $signed(E_W'(ady_reg));
        xph_c     = keep2 >= -$signed(E_W'(adx_reg));
        yph_raw_c = keep2 <= $signed(E_W'(ady_reg));
        donex_c   = xph_c && (cur_x_reg == end_x_reg);
        budget    = (N_W'(n_reg + N_W'(1))) < N_W'(MAX_SPAN_PIXELS);
        y_start   = yph_reg && budget && lt_lim(ey0, lim_reg)
                    && ((end_x_reg != cur_x_reg) || (adx_reg < ady_reg));
    end

    // next pixel of the step, if any
    always_comb begin
        has_next = 1'b0;
        nph      = phase_reg;
        nx       = pix_x_reg;
        ny       = pix_y_reg;
        ne       = epix_reg;
        unique case (phase_reg)
            atlr_pkg::PH_CENTRE: begin
                if (xph_reg && budget && lt_lim(ex0, lim_reg)
                    && ((end_y_reg != cur_y_reg) || (adx_reg > ady_reg))) begin
                    has_next = 1'b1;
                    nph      = atlr_pkg::PH_XSPAN;
                    nx       = cur_x_reg;
                    ny       = cur_y_reg + sy_add;
                    ne       = ex0;
                end else if (y_start) begin
                    has_next = 1'b1;
                    nph      = atlr_pkg::PH_YSPAN;
                    nx       = cur_x_reg + sx_add;
                    ny       = cur_y_reg;
                    ne       = ey0;
                end
            end
            atlr_pkg::PH_XSPAN: begin
                if (budget && lt_lim(exn, lim_reg)
                    && ((end_y_reg != pix_y_reg) || (adx_reg > ady_reg))) begin
                    has_next = 1'b1;
                    nph      = atlr_pkg::PH_XSPAN;
                    nx       = cur_x_reg;
                    ny       = pix_y_reg + sy_add;
                    ne       = exn;
                end else if (y_start) begin
                    has_next = 1'b1;
                    nph      = atlr_pkg::PH_YSPAN;
                    nx       = cur_x_reg + sx_add;
                    ny       = cur_y_reg;
                    ne       = ey0;
                end
            end
            atlr_pkg::PH_YSPAN: begin
                if (budget && lt_lim(eyn, lim_reg)
                    && ((end_x_reg != pix_x_reg) || (adx_reg < ady_reg))) begin
                    has_next = 1'b1;
                    nph      = atlr_pkg::PH_YSPAN;
                    nx       = pix_x_reg + sx_add;
                    ny       = cur_y_reg;
                    ne       = eyn;
                end
            end
            default: begin
                has_next = 1'b0;
            end
        endcase
    end

    // sequencer: next state and datapath
    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        active_next  = active_reg;
        shift_next   = shift_reg;
        m_valid_next = m_valid_reg;
        cur_x_next   = cur_x_reg;
        cur_y_next   = cur_y_reg;
        end_x_next   = end_x_reg;
        end_y_next   = end_y_reg;
        adx_next     = adx_reg;
        ady_next     = ady_reg;
        sxn_next     = sxn_reg;
        syn_next     = syn_reg;
        err_next     = err_reg;
        len_next     = len_reg;
        recip_next   = recip_reg;
        width_next   = width_reg;
        base_next    = base_reg;
        lim_next     = lim_reg;
        acc_next     = acc_reg;
        rem_next     = rem_reg;
        root_next    = root_reg;
        bit_next     = bit_reg;
        num_next     = num_reg;
        cnt_next     = cnt_reg;
        prod_next    = prod_reg;
        q_next       = q_reg;
        pix_x_next   = pix_x_reg;
        pix_y_next   = pix_y_reg;
        epix_next    = epix_reg;
        n_next       = n_reg;
        xph_next     = xph_reg;
        yph_next     = yph_reg;
        donex_next   = donex_reg;
        done_next    = done_reg;
        mx_next      = mx_reg;
        my_next      = my_reg;
        mval_next    = mval_reg;
        mlast_next   = mlast_reg;
        mdone_next   = mdone_reg;
        mul_a        = '0;
        mul_b        = '0;
        sq           = '0;
        trial        = '0;
        rootv        = '0;
        dt           = '0;
        lenv         = '0;
        err1         = err_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (psel && penable && pwrite && (paddr[2] == atlr_pkg::REG_ALPHA_SHIFT)) begin
            shift_next = pwdata[atlr_pkg::SHIFT_W-1:0];
        end

        unique case (state_reg)
            atlr_pkg::ST_IDLE: begin
                if (s_fire && (s_command == atlr_pkg::CMD_LOAD)) begin
                    cur_x_next  = s_x_start;
                    cur_y_next  = s_y_start;
                    end_x_next  = s_x_end;
                    end_y_next  = s_y_end;
                    adx_next    = (s_x_start < s_x_end) ? s_x_end - s_x_start
                                                        : s_x_start - s_x_end;
                    ady_next    = (s_y_start < s_y_end) ? s_y_end - s_y_start
                                                        : s_y_start - s_y_end;
                    sxn_next    = !(s_x_start < s_x_end);
                    syn_next    = !(s_y_start < s_y_end);
                    err_next    = $signed(ERR_W'(adx_next)) - $signed(ERR_W'(ady_next));
                    width_next  = s_line_width;
                    base_next   = s_base_pixel;
                    active_next = 1'b1;
                    state_next  = atlr_pkg::ST_SQX;
                end else if (s_fire && active_reg) begin
                    // centre pixel of the step; the step's shape is settled here
                    pix_x_next = cur_x_reg;
                    pix_y_next = cur_y_reg;
                    epix_next  = e0;
                    phase_next = atlr_pkg::PH_CENTRE;
                    n_next     = '0;
                    xph_next   = xph_c;
                    donex_next = donex_c;
                    yph_next   = !donex_c && yph_raw_c;
                    done_next  = donex_c || (!donex_c && yph_raw_c
                                             && (cur_y_reg == end_y_reg));
                    state_next = atlr_pkg::ST_M1;
                end
            end
            atlr_pkg::ST_SQX: begin
                mul_a      = MA_W'(adx_reg);
                mul_b      = MB_W'(adx_reg);
                acc_next   = mul_p[SQ_W-1:0];
                state_next = atlr_pkg::ST_SQY;
            end
            atlr_pkg::ST_SQY: begin
                mul_a = MA_W'(ady_reg);
                mul_b = MB_W'(ady_reg);
                sq    = acc_reg + mul_p[SQ_W-1:0];
                cnt_next = '0;
                if (sq == '0) begin
                    // single point: length is exactly one
                    rem_next   = '0;
                    root_next  = V_W'(atlr_pkg::LEN_ONE);
                    state_next = atlr_pkg::ST_RFIX;
                end else begin
                    rem_next   = V_W'(sq) << atlr_pkg::SQ_FRAC;
                    root_next  = '0;
                    bit_next   = V_W'(1) << (2 * (ROOT_W - 1));
                    state_next = atlr_pkg::ST_ROOT;
                end
            end
            atlr_pkg::ST_ROOT: begin
                // one result bit per cycle
                trial = root_reg + bit_reg;
                if (rem_reg >= trial) begin
                    rem_next  = rem_reg - trial;
                    root_next = (root_reg >> 1) + bit_reg;
                end else begin
                    root_next = root_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                cnt_next = cnt_reg + atlr_pkg::CNT_W'(1);
                if (cnt_reg == atlr_pkg::CNT_W'(ROOT_W - 1)) begin
                    state_next = atlr_pkg::ST_RFIX;
                end
            end
            atlr_pkg::ST_RFIX: begin
                // round to nearest, then seed the reciprocal
                rootv      = (rem_reg > root_reg) ? root_reg + V_W'(1) : root_reg;
                lenv       = rootv[ROOT_W-1:0];
                len_next   = lenv;
                num_next   = (atlr_pkg::NUM_W'(1) << (atlr_pkg::NUM_W - 1))
                             + atlr_pkg::NUM_W'(lenv >> 1);
                rem_next   = '0;
                cnt_next   = '0;
                state_next = atlr_pkg::ST_DIV;
            end
            atlr_pkg::ST_DIV: begin
                // restoring division, one quotient bit per cycle
                dt = {rem_reg[ROOT_W-1:0], num_reg[atlr_pkg::NUM_W-1]};
                if (dt >= {1'b0, len_reg}) begin
                    rem_next = V_W'(dt - {1'b0, len_reg});
                    num_next = {num_reg[atlr_pkg::NUM_W-2:0], 1'b1};
                end else begin
                    rem_next = V_W'(dt);
                    num_next = {num_reg[atlr_pkg::NUM_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + atlr_pkg::CNT_W'(1);
                if (cnt_reg == atlr_pkg::CNT_W'(atlr_pkg::NUM_W - 1)) begin
                    state_next = atlr_pkg::ST_LIM;
                end
            end
            atlr_pkg::ST_LIM: begin
                recip_next = num_reg[atlr_pkg::RECIP_W-1:0];
                mul_a      = MA_W'(len_reg);
                mul_b      = MB_W'(width_reg) + MB_W'(atlr_pkg::WIDTH_ONE);
                lim_next   = mul_p[LIM_W-1:0];
                state_next = atlr_pkg::ST_IDLE;
            end
            atlr_pkg::ST_M1: begin
                mul_a      = MA_W'(mag);
                mul_b      = MB_W'(recip_reg[atlr_pkg::RECIP_HALF-1:0]);
                prod_next  = mul_p;
                state_next = atlr_pkg::ST_M2;
            end
            atlr_pkg::ST_M2: begin
                mul_a      = MA_W'(mag);
                mul_b      = MB_W'(recip_reg[atlr_pkg::RECIP_W-1:atlr_pkg::RECIP_HALF]);
                q_next     = QW'(prod_reg) + (QW'(mul_p) << atlr_pkg::RECIP_HALF);
                state_next = atlr_pkg::ST_EMIT;
            end
            atlr_pkg::ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    mx_next      = pix_x_reg;
                    my_next      = pix_y_reg;
                    mval_next    = pix_value;
                    mlast_next   = !has_next;
                    mdone_next   = done_reg;
                    if (has_next) begin
                        phase_next = nph;
                        pix_x_next = nx;
                        pix_y_next = ny;
                        epix_next  = ne;
                        n_next     = n_reg + N_W'(1);
                        state_next = atlr_pkg::ST_M1;
                    end else begin
                        // advance the walk at the end of the step
                        if (xph_reg && !donex_reg) begin
                            err1       = err_reg - $signed(ERR_W'(ady_reg));
                            cur_x_next = cur_x_reg + sx_add;
                        end
                        if (yph_reg && (cur_y_reg != end_y_reg)) begin
                            err_next   = err1 + $signed(ERR_W'(adx_reg));
                            cur_y_next = cur_y_reg + sy_add;
                        end else begin
                            err_next = err1;
                        end
                        if (done_reg) begin
                            active_next = 1'b0;
                        end
                        state_next = atlr_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = atlr_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= atlr_pkg::ST_IDLE;
            phase_reg   <= atlr_pkg::PH_CENTRE;
            active_reg  <= 1'b0;
            shift_reg   <= atlr_pkg::ALPHA_SHIFT_RST;
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
            n_reg       <= '0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            active_reg  <= active_next;
            shift_reg   <= shift_next;
            m_valid_reg <= m_valid_next;
            cnt_reg     <= cnt_next;
            n_reg       <= n_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        cur_x_reg  <= cur_x_next;
        cur_y_reg  <= cur_y_next;
        end_x_reg  <= end_x_next;
        end_y_reg  <= end_y_next;
        adx_reg    <= adx_next;
        ady_reg    <= ady_next;
        sxn_reg    <= sxn_next;
        syn_reg    <= syn_next;
        err_reg    <= err_next;
        len_reg    <= len_next;
        recip_reg  <= recip_next;
        width_reg  <= width_next;
        base_reg   <= base_next;
        lim_reg    <= lim_next;
        acc_reg    <= acc_next;
        rem_reg    <= rem_next;
        root_reg   <= root_next;
        bit_reg    <= bit_next;
        num_reg    <= num_next;
        prod_reg   <= prod_next;
        q_reg      <= q_next;
        pix_x_reg  <= pix_x_next;
        pix_y_reg  <= pix_y_next;
        epix_reg   <= epix_next;
        xph_reg    <= xph_next;
        yph_reg    <= yph_next;
        donex_reg  <= donex_next;
        done_reg   <= done_next;
        mx_reg     <= mx_next;
        my_reg     <= my_next;
        mval_reg   <= mval_next;
        mlast_reg  <= mlast_next;
        mdone_reg  <= mdone_next;
    end

endmodule

`default_nettype wire

// ----- design/atlr_alpha.sv -----
// coverage-to-alpha conversion and pixel word assembly
// depends on atlr_pkg
`timescale 1ns / 1ps
`default_nettype none

module atlr_alpha #(
    parameter int QW = 45
) (
    input  wire logic [QW-1:0]                   q,
    input  wire logic [atlr_pkg::WIDTH_W-1:0]    line_width,
    input  wire logic [atlr_pkg::PIX_W-1:0]      base,
    input  wire logic [atlr_pkg::SHIFT_W-1:0]    shift,
    output logic      [atlr_pkg::PIX_W-1:0]      value
);

    localparam int TW = QW + 8;
    localparam int AW = TW - atlr_pkg::ALPHA_FRAC;

    logic [QW-1:0] wq;
    logic [QW-1:0] diff;
    logic [TW-1:0] t;
    logic [AW-1:0] a;
    logic [7:0]    alpha;

    always_comb begin
        wq   = QW'(line_width) << atlr_pkg::WQ_SHIFT;
        diff = q - wq;
        // 255*diff + half lsb, then drop the fraction
        t    = (TW'(diff) << 8) - TW'(diff) + (TW'(1) << (atlr_pkg::ALPHA_FRAC - 1));
        a    = t[TW-1:atlr_pkg::ALPHA_FRAC];
        if (q <= wq) begin
            alpha = 8'd0;
        end else if (|a[AW-1:8]) begin
            alpha = 8'hff;
        end else begin
            alpha = a[7:0];
        end
        value = base | (atlr_pkg::PIX_W'(alpha) << shift);
    end

endmodule

`default_nettype wire

// ----- design/atlr_checker.sv -----
// port-level checks of the thick line rasterizer, bound to the top level
// depends on atlr_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module atlr_checker #(
    parameter int COORD_BITS = atlr_pkg::COORD_BITS_DEF
) (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_valid,
    input wire logic                          s_ready,
    input wire logic                          s_command,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic [COORD_BITS-1:0]         m_pixel_x,
    input wire logic [COORD_BITS-1:0]         m_pixel_y,
    input wire logic [atlr_pkg::PIX_W-1:0]    m_pixel_value,
    input wire logic                          m_last_of_step,
    input wire logic                          m_line_done
);

    logic out_stall;
    logic load_fire;
    logic mid_step;

    assign out_stall = m_valid && !m_ready;
    assign load_fire = s_valid && s_ready && (s_command == atlr_pkg::CMD_LOAD);
    assign mid_step  = m_valid && !m_last_of_step;

    // a stalled pixel beat holds
    `ATLR_ASSERT_NXT(a_out_hold, out_stall, m_valid && $stable(m_pixel_x) && $stable(m_pixel_y) && $stable(m_pixel_value))
    // a load keeps the block busy with the length computation
    `ATLR_ASSERT_NXT(a_load_busy, load_fire, !s_ready && !m_valid || !s_ready)
    // no command is taken while a step still has pixels to send
    `ATLR_ASSERT_IMP(a_step_busy, mid_step, !s_ready)
    // a set line_done holds across the remaining pixels of a step
    `ATLR_ASSERT_NXT(a_done_steady, m_valid && m_ready && !m_last_of_step && m_line_done, !m_valid || m_line_done)

endmodule

bind antialiased_thick_line_raster atlr_checker #(
    .COORD_BITS (COORD_BITS)
) u_atlr_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .s_command      (s_command),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_pixel_x      (m_pixel_x),
    .m_pixel_y      (m_pixel_y),
    .m_pixel_value  (m_pixel_value),
    .m_last_of_step (m_last_of_step),
    .m_line_done    (m_line_done)
);

`default_nettype wire

// ----- tb/atlr_pixel_checker.sv -----
// pixel stream checker for the thick line rasterizer: snoops command beats,
// register writes and pixel beats, predicts every pixel and compares
// depends on atlr_pkg
`timescale 1ns / 1ps
`default_nettype none

module atlr_pixel_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic        s_command,
    input  wire logic [11:0] s_x_start,
    input  wire logic [11:0] s_y_start,
    input  wire logic [11:0] s_x_end,
    input  wire logic [11:0] s_y_end,
    input  wire logic [7:0]  s_line_width,
    input  wire logic [31:0] s_base_pixel,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [11:0] m_pixel_x,
    input  wire logic [11:0] m_pixel_y,
    input  wire logic [31:0] m_pixel_value,
    input  wire logic        m_last_of_step,
    input  wire logic        m_line_done,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        pready,
    output int               fail_count,
    output int               pixels_pending,
    output int               pixels_checked,
    output int               lines_finished
);

    localparam int MAX_SPAN = atlr_pkg::MAX_SPAN_DEF;

    typedef struct {
        logic [11:0] x;
        logic [11:0] y;
        logic [31:0] value;
        logic        last;
        logic        done;
    } pixel_t;

    pixel_t      expected_pixels[$];

    // shadow of the rasterizer state
    logic [4:0]  shift_q;
    logic [11:0] pos_x, pos_y, stop_x, stop_y, dx_mag, dy_mag;
    logic        x_neg, y_neg, walking;
    longint      walk_err;
    longint      len_q8;
    longint      inv_len;
    longint      weight_p1;
    logic [31:0] colour;

    function automatic longint unsigned root_round(longint unsigned v);
        longint unsigned rem, r, b;
        rem = v;
        r = 0;
        b = 64'd1 << 62;
        while (b > rem) b = b >> 2;
        while (b != 0) begin
            if (rem >= r + b) begin
                rem = rem - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        if (v - r * r > r) r++;
        return r;
    endfunction

    function automatic logic [7:0] alpha_for(longint e);
        longint unsigned mag, q, wq, a;
        mag = (e < 0) ? -e : e;
        q = mag * longint'(inv_len);
        wq = longint'(weight_p1 - atlr_pkg::WIDTH_ONE) << atlr_pkg::WQ_SHIFT;
        if (q <= wq) return 8'd0;
        a = (255 * (q - wq) + (64'd1 << 22)) >> atlr_pkg::ALPHA_FRAC;
        return (a > 255) ? 8'd255 : a[7:0];
    endfunction

    function automatic pixel_t shade(logic [11:0] x, logic [11:0] y, longint e);
        pixel_t p;
        logic [31:0] av;
        av = {24'd0, alpha_for(e)} << shift_q;
        p.x = x;
        p.y = y;
        p.value = colour | av;
        p.last = 1'b0;
        p.done = 1'b0;
        return p;
    endfunction

    task automatic latch_line(logic [11:0] xs, logic [11:0] ys, logic [11:0] xe,
                              logic [11:0] ye, logic [7:0] w, logic [31:0] base);
        longint unsigned sq;
        pos_x = xs; pos_y = ys; stop_x = xe; stop_y = ye;
        dx_mag = (xs < xe) ? xe - xs : xs - xe;
        dy_mag = (ys < ye) ? ye - ys : ys - ye;
        x_neg = !(xs < xe);
        y_neg = !(ys < ye);
        walk_err = longint'(dx_mag) - longint'(dy_mag);
        sq = longint'(dx_mag) * dx_mag + longint'(dy_mag) * dy_mag;
        len_q8 = (sq == 0) ? atlr_pkg::LEN_ONE : root_round(sq << atlr_pkg::SQ_FRAC);
        inv_len = ((64'd1 << 31) + len_q8 / 2) / len_q8;
        weight_p1 = longint'(w) + atlr_pkg::WIDTH_ONE;
        colour = base;
        walking = 1'b1;
    endtask

    // one iteration of the error walk: centre pixel, x-move span, y-move span
    task automatic walk_one_step();
        pixel_t      burst[$];
        longint      ax, ay, e, lim, keep;
        logic [11:0] px, py, sx, sy;
        logic        finished;
        finished = 1'b0;
        ax = dx_mag;
        ay = dy_mag;
        sx = x_neg ? 12'hFFF : 12'd1;
        sy = y_neg ? 12'hFFF : 12'd1;
        lim = len_q8 * weight_p1;
        burst.push_back(shade(pos_x, pos_y, walk_err - ax + ay));
        keep = walk_err;
        px = pos_x;
        if (keep * 2 >= -ax) begin
            py = pos_y;
            e = keep + ay;
            while (e * 4096 < lim && (stop_y != py || ax > ay) && burst.size() < MAX_SPAN) begin
                py = py + sy;
                burst.push_back(shade(pos_x, py, e));
                e = e + ax;
            end
            if (pos_x == stop_x) begin
                finished = 1'b1;
            end else begin
                keep = walk_err;
                walk_err = walk_err - ay;
                pos_x = pos_x + sx;
            end
        end
        if (!finished && keep * 2 <= ay) begin
            e = ax - keep;
            while (e * 4096 < lim && (stop_x != px || ax < ay) && burst.size() < MAX_SPAN) begin
                px = px + sx;
                burst.push_back(shade(px, pos_y, e));
                e = e + ay;
            end
            if (pos_y == stop_y) finished = 1'b1;
            else begin
                walk_err = walk_err + ax;
                pos_y = pos_y + sy;
            end
        end
        if (finished) begin
            walking = 1'b0;
            lines_finished++;
            foreach (burst[i]) burst[i].done = 1'b1;
        end
        burst[burst.size() - 1].last = 1'b1;
        foreach (burst[i]) expected_pixels.push_back(burst[i]);
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("[%0t] pixel mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what,
                 got, want);
        fail_count++;
    endtask

    initial begin
        fail_count = 0;
        pixels_checked = 0;
        lines_finished = 0;
        shift_q = atlr_pkg::ALPHA_SHIFT_RST;
        walking = 1'b0;
        pos_x = '0; pos_y = '0; stop_x = '0; stop_y = '0; dx_mag = '0; dy_mag = '0;
        x_neg = 1'b0; y_neg = 1'b0;
        walk_err = 0; len_q8 = 0; inv_len = 0; weight_p1 = 0; colour = '0;
    end

    assign pixels_pending = expected_pixels.size();

    always @(posedge aclk) begin
        pixel_t want;
        if (aresetn) begin
            if (psel && penable && pwrite && pready
                && paddr[2] == atlr_pkg::REG_ALPHA_SHIFT)
                shift_q = pwdata[4:0];
            if (s_valid && s_ready) begin
                if (s_command == atlr_pkg::CMD_LOAD)
                    latch_line(s_x_start, s_y_start, s_x_end, s_y_end, s_line_width,
                               s_base_pixel);
                else if (walking)
                    walk_one_step();
            end
            if (m_valid && m_ready) begin
                if (expected_pixels.size() == 0) begin
                    report_mismatch("unexpected beat x", m_pixel_x, 0);
                end else begin
                    want = expected_pixels.pop_front();
                    pixels_checked++;
                    if (m_pixel_x !== want.x) report_mismatch("pixel_x", m_pixel_x, want.x);
                    if (m_pixel_y !== want.y) report_mismatch("pixel_y", m_pixel_y, want.y);
                    if (m_pixel_value !== want.value)
                        report_mismatch("pixel_value", m_pixel_value, want.value);
                    if (m_last_of_step !== want.last)
                        report_mismatch("last_of_step", m_last_of_step, want.last);
                    if (m_line_done !== want.done)
                        report_mismatch("line_done", m_line_done, want.done);
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// top of the thick line rasterizer testbench: clock, reset, command beats,
// register writes and the verdict; depends on atlr_pkg, atlr_pixel_checker
// and antialiased_thick_line_raster
`timescale 1ns / 1ps
`default_nettype none

module tb;

    logic        aclk;
    logic        aresetn;
    logic        s_valid, s_ready, s_command;
    logic [11:0] s_x_start, s_y_start, s_x_end, s_y_end;
    logic [7:0]  s_line_width;
    logic [31:0] s_base_pixel;
    logic        m_valid, m_ready;
    logic [11:0] m_pixel_x, m_pixel_y;
    logic [31:0] m_pixel_value;
    logic        m_last_of_step, m_line_done;
    logic        psel, penable, pwrite, pready;
    logic [2:0]  paddr;
    logic [31:0] pwdata, prdata;

    int fail_count, pixels_pending, pixels_checked, lines_finished;
    int beats_sent;
    // when set, neither side inserts idle cycles
    logic calm;

    antialiased_thick_line_raster uut (.*);

    atlr_pixel_checker pixel_check (.*);

    always #5 aclk = ~aclk;

    // pixel sink: back-pressure on about 8 percent of cycles, none while calm
    always @(posedge aclk) begin
        m_ready <= calm || ($urandom_range(99) >= 8);
    end

    // one command beat; step_line gives the fields the block ignores on a step random values
    task automatic send_beat(logic cmd, logic [11:0] xs, logic [11:0] ys, logic [11:0] xe,
                             logic [11:0] ye, logic [7:0] w, logic [31:0] base);
        if (!calm && $urandom_range(99) < 8) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_command    <= cmd;
        s_x_start    <= xs;
        s_y_start    <= ys;
        s_x_end      <= xe;
        s_y_end      <= ye;
        s_line_width <= w;
        s_base_pixel <= base;
        do @(posedge aclk); while (!s_ready);
        beats_sent++;
    endtask

    task automatic step_line(int count);
        repeat (count)
            send_beat(atlr_pkg::CMD_STEP, 12'($urandom), 12'($urandom), 12'($urandom),
                      12'($urandom), 8'($urandom), $urandom);
    endtask

    task automatic draw_line(logic [11:0] xs, logic [11:0] ys, logic [11:0] xe, logic [11:0] ye,
                             logic [7:0] w, logic [31:0] base, int steps);
        send_beat(atlr_pkg::CMD_LOAD, xs, ys, xe, ye, w, base);
        step_line(steps);
    endtask

    // register writes only with the block drained; a load makes no pixels,
    // so allow for its length computation as well
    task automatic write_alpha_shift(logic [4:0] v);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pixels_pending != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {atlr_pkg::REG_ALPHA_SHIFT, 2'b00};
        pwdata  <= {27'($urandom), v};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // mostly short lines that run to their end, some cut short by a new load,
    // a few with endpoints anywhere on the grid
    task automatic random_lines(int budget);
        int          start_count, dx, dy, len, steps;
        logic [11:0] xs, ys, xe, ye;
        logic [7:0]  w;
        start_count = beats_sent;
        while (beats_sent - start_count < budget) begin
            xs = 12'($urandom);
            ys = 12'($urandom);
            w  = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 48));
            if ($urandom_range(19) == 0) begin
                xe = 12'($urandom);
                ye = 12'($urandom);
                steps = $urandom_range(1, 3);
            end else begin
                dx = $signed($urandom_range(0, 30)) - 15;
                dy = $signed($urandom_range(0, 30)) - 15;
                xe = 12'((int'(xs) + dx < 0) ? 0 :
                         (int'(xs) + dx > 4095) ? 4095 : int'(xs) + dx);
                ye = 12'((int'(ys) + dy < 0) ? 0 :
                         (int'(ys) + dy > 4095) ? 4095 : int'(ys) + dy);
                len = (dx < 0 ? -dx : dx) > (dy < 0 ? -dy : dy) ?
                      (dx < 0 ? -dx : dx) : (dy < 0 ? -dy : dy);
                steps = ($urandom_range(6) == 0) ? $urandom_range(0, len)
                                                 : len + 1 + $urandom_range(0, 2);
            end
            draw_line(xs, ys, xe, ye, w, $urandom, steps);
        end
    endtask

    initial begin
        aclk = 1'b0;
        aresetn = 1'b0;
        calm = 1'b0;
        beats_sent = 0;
        s_valid = 1'b0; s_command = atlr_pkg::CMD_LOAD;
        s_x_start = '0; s_y_start = '0; s_x_end = '0; s_y_end = '0;
        s_line_width = '0; s_base_pixel = '0;
        m_ready = 1'b1;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: step before any line, single point, axis lines, diagonals,
        // coordinate extremes, wrap of spans past the grid edge, widest weight
        step_line(1);
        draw_line(12'd5, 12'd5, 12'd5, 12'd5, 8'd0, 32'h0000_0000, 2);
        draw_line(12'd0, 12'd0, 12'd4, 12'd0, 8'd40, 32'hFFFF_FFFF, 5);
        draw_line(12'd4095, 12'd4095, 12'd4095, 12'd4091, 8'd24, 32'h00A5_5A00, 5);
        draw_line(12'd4095, 12'd0, 12'd4092, 12'd3, 8'd8, 32'h1234_5678, 4);
        draw_line(12'd0, 12'd0, 12'd3, 12'd0, 8'd255, 32'h0000_00FF, 4);
        draw_line(12'd0, 12'd4095, 12'd2, 12'd4090, 8'd255, 32'hFF00_0000, 3);
        // a long line cut short by the next load
        draw_line(12'd0, 12'd0, 12'd4095, 12'd4095, 8'd16, 32'h8000_0001, 2);

        // settings of the alpha offset, extremes among them
        write_alpha_shift(5'd0);
        random_lines(30);
        write_alpha_shift(5'd31);
        draw_line(12'd100, 12'd100, 12'd103, 12'd101, 8'd200, 32'h0, 4);
        random_lines(30);
        write_alpha_shift(5'd24);
        calm = 1'b1;
        random_lines(30);
        calm = 1'b0;
        write_alpha_shift(5'($urandom_range(1, 30)));
        random_lines(30);
        write_alpha_shift(5'($urandom_range(1, 30)));
        random_lines(30);

        s_valid <= 1'b0;
        @(posedge aclk);
        while (pixels_pending != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        $display("covered %0d command beats, %0d pixels checked, %0d lines walked to their end",
                 beats_sent, pixels_checked, lines_finished);
        if (fail_count == 0 && pixels_pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5ms;
        $display("timeout with %0d pixels still expected", pixels_pending);
        $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
